// ===== hdl/irtl_pkg.sv =====
// Shared types and constants of the IPv4 range table lookup block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package irtl_pkg;

	// Range table geometry.
	localparam int RANGE_DEPTH = 65536;
	localparam int RANGE_AW    = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1;

	// Field widths fixed by the item format.
	localparam int ADDR_W = 32;
	localparam int SLOT_W = 16;
	localparam int OFS_W  = 24;
	localparam int LEN_W  = 8;
	localparam int OCT_W  = 8;
	localparam int MODE_W = 2;

	// Item modes.
	localparam logic [MODE_W-1:0] MODE_WR_RANGE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WR_PREFIX = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY     = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0] start_addr;
		logic [ADDR_W-1:0] end_addr;
		logic [OFS_W-1:0]  offset;
		logic [LEN_W-1:0]  length;
	} range_rec_t;

	typedef struct packed {
		logic [SLOT_W-1:0] first;
		logic [SLOT_W-1:0] last;
	} slice_rec_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PFX,
		ST_SEARCH,
		ST_CHECK,
		ST_MISS
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_START,
		OP_SLICE,
		OP_STEP,
		OP_CHECK,
		OP_MISS
	} dp_op_t;

	typedef struct packed {
		logic   take;
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic pfx_valid;
		logic pfx_search;
		logic step_more;
		logic out_free;
	} status_t;

endpackage

// ===== hdl/ip_range_table_lookup_top.sv =====
// Top level of the IPv4 range table lookup with a first-octet prefix index.
// Depends on irtl_pkg, irtl_ctrl and irtl_datapath.
`timescale 1ns / 1ps

// How the block is used.
// The input channel (in_valid / in_stall) carries one item per handshake. An item
// with mode 0 loads one range table slot, mode 1 loads the prefix slot of one
// first octet, mode 2 looks up query_ip, and mode 3 is dropped. Only lookups
// produce a result item, on the output channel (out_valid / out_stall).
// A table load leaves the controller idle; the next item can be taken in the cycle after.
// A lookup reads the prefix slot in its accept cycle, examines it in the next,
// then runs a binary search that does one range memory read per cycle, and
// checks the chosen slot once the output register is free. The input channel is
// held after the accept until the result is written to the output register.
// A missing prefix skips the search and the check and gives a miss result;
// single-entry and reversed slices skip only the search.
// The result sits in an output register; if the receiver stalls, the next lookup
// still runs and waits in its check or miss step until that register is free.
// Reset clears every prefix valid bit, the output valid and the control state at once. Range slots
// hold no reset value and must be loaded before any lookup can reach them.

module ip_range_table_lookup_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [irtl_pkg::MODE_W-1:0]  mode,
	input  logic [irtl_pkg::SLOT_W-1:0]  entry_index,
	input  logic [irtl_pkg::ADDR_W-1:0]  range_start,
	input  logic [irtl_pkg::ADDR_W-1:0]  range_end,
	input  logic [irtl_pkg::OFS_W-1:0]   loc_offset,
	input  logic [irtl_pkg::LEN_W-1:0]   loc_length,
	input  logic [irtl_pkg::OCT_W-1:0]   prefix,
	input  logic [irtl_pkg::SLOT_W-1:0]  first_slot,
	input  logic [irtl_pkg::SLOT_W-1:0]  last_slot,
	input  logic [irtl_pkg::ADDR_W-1:0]  query_ip,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit,
	output logic [irtl_pkg::SLOT_W-1:0]  found_index,
	output logic [irtl_pkg::ADDR_W-1:0]  found_start,
	output logic [irtl_pkg::ADDR_W-1:0]  found_end,
	output logic [irtl_pkg::OFS_W-1:0]   found_offset,
	output logic [irtl_pkg::LEN_W-1:0]   found_length
);
	import irtl_pkg::*;

	// Commands flow from the controller to the datapath, status flows back.
	cmd_t    cmd;
	status_t sts;

	irtl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	irtl_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.mode         (mode),
		.entry_index  (entry_index),
		.range_start  (range_start),
		.range_end    (range_end),
		.loc_offset   (loc_offset),
		.loc_length   (loc_length),
		.prefix       (prefix),
		.first_slot   (first_slot),
		.last_slot    (last_slot),
		.query_ip     (query_ip),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.found_index  (found_index),
		.found_start  (found_start),
		.found_end    (found_end),
		.found_offset (found_offset),
		.found_length (found_length)
	);

endmodule

// ===== hdl/irtl_ctrl.sv =====
// Controller of the range table lookup: sequences prefix read, search and check or miss.
// Depends on irtl_pkg; drives the datapath only through cmd_t and reads status_t.
`timescale 1ns / 1ps

module irtl_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [irtl_pkg::MODE_W-1:0] mode,
	output logic                       in_stall,
	input  irtl_pkg::status_t          sts,
	output irtl_pkg::cmd_t             cmd
);
	import irtl_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && (mode == MODE_QUERY)) begin
					state_d = ST_PFX;
				end
			end
			ST_PFX: begin
				if (!sts.pfx_valid) begin
					state_d = ST_MISS;
				end else if (sts.pfx_search) begin
					state_d = ST_SEARCH;
				end else begin
					state_d = ST_CHECK;
				end
			end
			ST_SEARCH: begin
				if (!sts.step_more) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK, ST_MISS: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.take = 1'b0;
		cmd.op   = OP_NONE;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				cmd.take = in_valid;
				if (in_valid && (mode == MODE_QUERY)) begin
					cmd.op = OP_START;
				end
			end
			ST_PFX:    cmd.op = OP_SLICE;
			ST_SEARCH: cmd.op = OP_STEP;
			ST_CHECK: begin
				if (sts.out_free) begin
					cmd.op = OP_CHECK;
				end
			end
			ST_MISS: begin
				if (sts.out_free) begin
					cmd.op = OP_MISS;
				end
			end
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

// ===== hdl/irtl_datapath.sv =====
// Datapath of the range table lookup: range and prefix memories, search registers
// and the output register. Depends on irtl_pkg; commanded by irtl_ctrl.
`timescale 1ns / 1ps

module irtl_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  irtl_pkg::cmd_t               cmd,
	output irtl_pkg::status_t            sts,
	input  logic [irtl_pkg::MODE_W-1:0]  mode,
	input  logic [irtl_pkg::SLOT_W-1:0]  entry_index,
	input  logic [irtl_pkg::ADDR_W-1:0]  range_start,
	input  logic [irtl_pkg::ADDR_W-1:0]  range_end,
	input  logic [irtl_pkg::OFS_W-1:0]   loc_offset,
	input  logic [irtl_pkg::LEN_W-1:0]   loc_length,
	input  logic [irtl_pkg::OCT_W-1:0]   prefix,
	input  logic [irtl_pkg::SLOT_W-1:0]  first_slot,
	input  logic [irtl_pkg::SLOT_W-1:0]  last_slot,
	input  logic [irtl_pkg::ADDR_W-1:0]  query_ip,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit,
	output logic [irtl_pkg::SLOT_W-1:0]  found_index,
	output logic [irtl_pkg::ADDR_W-1:0]  found_start,
	output logic [irtl_pkg::ADDR_W-1:0]  found_end,
	output logic [irtl_pkg::OFS_W-1:0]   found_offset,
	output logic [irtl_pkg::LEN_W-1:0]   found_length
);
	import irtl_pkg::*;

	localparam int OCT_N = 1 << OCT_W;

	range_rec_t range_mem [RANGE_DEPTH];
	slice_rec_t slice_mem [OCT_N];
	logic [OCT_N-1:0] slice_valid_q;

	range_rec_t rd_q;
	logic       rd_oob_q;
	slice_rec_t pfx_rd_q;
	logic       pfx_valid_q;
	logic [ADDR_W-1:0] addr_q;

	// Search bounds are one bit wider than a slot so lo can pass hi.
	logic [SLOT_W:0]   lo_q;
	logic [SLOT_W:0]   hi_q;
	logic [SLOT_W-1:0] pick_q;
	logic [SLOT_W-1:0] mid_q;

	logic              out_valid_q;

	logic [31:0]         wr_slot32;
	logic                wr_in_range;
	logic [SLOT_W-1:0]   rd_addr;
	logic                rd_en;
	logic [31:0]         rd_slot32;
	logic                rd_oob;

	logic                pfx_single;
	logic                pfx_ordered;
	logic [SLOT_W:0]     slice_sum;
	logic [ADDR_W-1:0]   end_eff;
	logic [ADDR_W-1:0]   start_eff;
	logic                ge;
	logic                brk;
	logic [SLOT_W:0]     nlo;
	logic [SLOT_W:0]     nhi;
	logic [SLOT_W-1:0]   npick;
	logic                step_more;
	logic [SLOT_W+1:0]   step_sum;
	logic                out_free;

	assign wr_slot32   = {{(32-SLOT_W){1'b0}}, entry_index};
	assign wr_in_range = (wr_slot32 < 32'(RANGE_DEPTH));
	assign rd_slot32   = {{(32-SLOT_W){1'b0}}, rd_addr};
	assign rd_oob      = (rd_slot32 >= 32'(RANGE_DEPTH));

	assign pfx_single  = (pfx_rd_q.first == pfx_rd_q.last);
	assign pfx_ordered = (pfx_rd_q.first <= pfx_rd_q.last);
	assign slice_sum   = {1'b0, pfx_rd_q.first} + {1'b0, pfx_rd_q.last};

	// A slot beyond the table reads as all zero fields.
	assign end_eff   = rd_oob_q ? '0 : rd_q.end_addr;
	assign start_eff = rd_oob_q ? '0 : rd_q.start_addr;
	assign ge        = (end_eff >= addr_q);

	always_comb begin
		nlo   = lo_q;
		nhi   = hi_q;
		npick = pick_q;
		brk   = 1'b0;
		if (ge) begin
			npick = mid_q;
			if (mid_q == '0) begin
				brk = 1'b1;
			end else begin
				nhi = {1'b0, mid_q} - {{SLOT_W{1'b0}}, 1'b1};
			end
		end else begin
			nlo = {1'b0, mid_q} + {{SLOT_W{1'b0}}, 1'b1};
		end
		step_more = !brk && (nlo <= nhi);
		step_sum  = {1'b0, nlo} + {1'b0, nhi};
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (cmd.op)
			OP_SLICE: begin
				rd_en = 1'b1;
				if (pfx_single) begin
					rd_addr = pfx_rd_q.first;
				end else if (pfx_ordered) begin
					rd_addr = slice_sum[SLOT_W:1];
				end else begin
					rd_addr = '0;
				end
			end
			OP_STEP: begin
				rd_en   = 1'b1;
				rd_addr = step_more ? step_sum[SLOT_W:1] : npick;
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = '0;
			end
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;

	assign sts.pfx_valid  = pfx_valid_q;
	assign sts.pfx_search = !pfx_single && pfx_ordered;
	assign sts.step_more  = step_more;
	assign sts.out_free   = out_free;

	// Range memory: one write port for loads, one registered read port for the search.
	always_ff @(posedge clk) begin
		if (cmd.take && (mode == MODE_WR_RANGE) && wr_in_range) begin
			range_mem[wr_slot32[RANGE_AW-1:0]] <= '{
				start_addr: range_start,
				end_addr:   range_end,
				offset:     loc_offset,
				length:     loc_length
			};
		end
		if (rd_en) begin
			rd_q     <= range_mem[rd_slot32[RANGE_AW-1:0]];
			rd_oob_q <= rd_oob;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && (mode == MODE_WR_PREFIX)) begin
			slice_mem[prefix] <= '{first: first_slot, last: last_slot};
		end
		if (cmd.op == OP_START) begin
			pfx_rd_q <= slice_mem[query_ip[ADDR_W-1 -: OCT_W]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_valid_q <= '0;
			pfx_valid_q   <= 1'b0;
		end else begin
			if (cmd.take && (mode == MODE_WR_PREFIX)) begin
				slice_valid_q[prefix] <= 1'b1;
			end
			if (cmd.op == OP_START) begin
				pfx_valid_q <= slice_valid_q[query_ip[ADDR_W-1 -: OCT_W]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_START) begin
			addr_q <= query_ip;
		end
		if (cmd.op == OP_SLICE) begin
			lo_q   <= {1'b0, pfx_rd_q.first};
			hi_q   <= {1'b0, pfx_rd_q.last};
			pick_q <= '0;
			mid_q  <= rd_addr;
		end else if (cmd.op == OP_STEP) begin
			lo_q   <= nlo;
			hi_q   <= nhi;
			pick_q <= npick;
			mid_q  <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.op == OP_CHECK) || (cmd.op == OP_MISS)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_CHECK) begin
			hit          <= (start_eff <= addr_q) && (end_eff >= addr_q);
			found_index  <= mid_q;
			found_start  <= start_eff;
			found_end    <= end_eff;
			found_offset <= rd_oob_q ? '0 : rd_q.offset;
			found_length <= rd_oob_q ? '0 : rd_q.length;
		end else if (cmd.op == OP_MISS) begin
			hit          <= 1'b0;
			found_index  <= '0;
			found_start  <= '0;
			found_end    <= '0;
			found_offset <= '0;
			found_length <= '0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== bench/tb_ip_range_table_lookup_top.sv =====
// Self-checking testbench of the IPv4 range table lookup with a first-octet prefix index.
// Depends on irtl_pkg and ip_range_table_lookup_top; runs a directed table, then random traffic.
`timescale 1ns / 1ps

module tb_ip_range_table_lookup_top;
	import irtl_pkg::*;

	localparam time HALF_PERIOD = 2ns;
	localparam int RANDOM_ITEMS = 1100;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT = 800000;
	// The block drops this mode without a result.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0] md;
		logic [SLOT_W-1:0] slot;
		logic [ADDR_W-1:0] st;
		logic [ADDR_W-1:0] en;
		logic [OFS_W-1:0]  ofs;
		logic [LEN_W-1:0]  len;
		logic [OCT_W-1:0]  oct;
		logic [SLOT_W-1:0] first;
		logic [SLOT_W-1:0] last;
		logic [ADDR_W-1:0] addr;
	} item_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] idx;
		logic [ADDR_W-1:0] st;
		logic [ADDR_W-1:0] en;
		logic [OFS_W-1:0]  ofs;
		logic [LEN_W-1:0]  len;
	} lookup_t;

	// One row of the directed table; want is used only where typed is set.
	typedef struct {
		item_t   it;
		bit      typed;
		lookup_t want;
	} dir_row_t;

	localparam lookup_t NO_PREFIX = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [MODE_W-1:0] mode = '0;
	logic [SLOT_W-1:0] entry_index = '0;
	logic [ADDR_W-1:0] range_start = '0;
	logic [ADDR_W-1:0] range_end = '0;
	logic [OFS_W-1:0]  loc_offset = '0;
	logic [LEN_W-1:0]  loc_length = '0;
	logic [OCT_W-1:0]  prefix = '0;
	logic [SLOT_W-1:0] first_slot = '0;
	logic [SLOT_W-1:0] last_slot = '0;
	logic [ADDR_W-1:0] query_ip = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic              hit;
	logic [SLOT_W-1:0] found_index;
	logic [ADDR_W-1:0] found_start;
	logic [ADDR_W-1:0] found_end;
	logic [OFS_W-1:0]  found_offset;
	logic [LEN_W-1:0]  found_length;

	ip_range_table_lookup_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .entry_index(entry_index),
		.range_start(range_start), .range_end(range_end),
		.loc_offset(loc_offset), .loc_length(loc_length),
		.prefix(prefix), .first_slot(first_slot), .last_slot(last_slot),
		.query_ip(query_ip),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .found_index(found_index),
		.found_start(found_start), .found_end(found_end),
		.found_offset(found_offset), .found_length(found_length)
	);

	// Shadow copy of the range table and the prefix table.
	logic [ADDR_W-1:0] rng_start [RANGE_DEPTH];
	logic [ADDR_W-1:0] rng_end [RANGE_DEPTH];
	logic [OFS_W-1:0]  rng_ofs [RANGE_DEPTH];
	logic [LEN_W-1:0]  rng_len [RANGE_DEPTH];
	bit                rng_loaded [RANGE_DEPTH];
	logic [SLOT_W-1:0] oct_first [256];
	logic [SLOT_W-1:0] oct_last [256];
	bit                oct_valid [256];

	// Range slots read by the latest call of predict_lookup.
	int unsigned probe_path[$];
	lookup_t lookup_expect[$];
	lookup_t oldest_lookup;
	dir_row_t dir_rows[$];

	int fail_count = 0;
	int unsigned items_taken = 0;
	int unsigned cycle_count = 0;
	int unsigned send_gap_pct = 23;
	int unsigned recv_stall_pct = 45;

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

	// Looks up one address in the shadow tables, the way the block does it.
	function automatic lookup_t predict_lookup(logic [ADDR_W-1:0] addr);
		lookup_t r;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		int unsigned pick;
		int unsigned slot;
		logic [SLOT_W-1:0] sel;
		r = '0;
		probe_path.delete();
		if (!oct_valid[addr[31:24]])
			return r;
		lo = 32'(oct_first[addr[31:24]]);
		hi = 32'(oct_last[addr[31:24]]);
		if (lo == hi) begin
			slot = lo;
		end else begin
			// Lowest slot whose end is not below the address; slot 0 if none is.
			pick = 0;
			while (lo <= hi) begin
				mid = (lo + hi) >> 1;
				probe_path.insert(probe_path.size(), mid);
				if (rng_end[SLOT_W'(mid)] >= addr) begin
					pick = mid;
					if (mid == 0)
						break;
					hi = mid - 1;
				end else begin
					lo = mid + 1;
				end
			end
			slot = pick;
		end
		probe_path.insert(probe_path.size(), slot);
		sel = SLOT_W'(slot);
		r.hit = (rng_start[sel] <= addr) && (rng_end[sel] >= addr);
		r.idx = sel;
		r.st = rng_start[sel];
		r.en = rng_end[sel];
		r.ofs = rng_ofs[sel];
		r.len = rng_len[sel];
		return r;
	endfunction

	function automatic item_t noise_item();
		item_t it;
		it.md = MODE_W'($urandom_range(3));
		it.slot = SLOT_W'($urandom);
		it.st = $urandom;
		it.en = $urandom;
		it.ofs = OFS_W'($urandom);
		it.len = LEN_W'($urandom);
		it.oct = OCT_W'($urandom);
		it.first = SLOT_W'($urandom);
		it.last = SLOT_W'($urandom);
		it.addr = $urandom;
		return it;
	endfunction

	function automatic item_t range_item(logic [SLOT_W-1:0] slot, logic [ADDR_W-1:0] st,
			logic [ADDR_W-1:0] en, logic [OFS_W-1:0] ofs, logic [LEN_W-1:0] len);
		item_t it;
		it = noise_item();
		it.md = MODE_WR_RANGE;
		it.slot = slot;
		it.st = st;
		it.en = en;
		it.ofs = ofs;
		it.len = len;
		return it;
	endfunction

	function automatic item_t prefix_item(logic [OCT_W-1:0] oct, logic [SLOT_W-1:0] first,
			logic [SLOT_W-1:0] last);
		item_t it;
		it = noise_item();
		it.md = MODE_WR_PREFIX;
		it.oct = oct;
		it.first = first;
		it.last = last;
		return it;
	endfunction

	function automatic item_t query_item(logic [ADDR_W-1:0] addr);
		item_t it;
		it = noise_item();
		it.md = MODE_QUERY;
		it.addr = addr;
		return it;
	endfunction

	task automatic add_row(dir_row_t row);
		dir_rows.insert(dir_rows.size(), row);
	endtask

	// Presents one item after a random gap and waits until the block takes it.
	// Returns at the falling edge after the accepting edge, with valid still high.
	task automatic send_item(item_t it, bit typed, lookup_t want);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= it.md;
		entry_index <= it.slot;
		range_start <= it.st;
		range_end <= it.en;
		loc_offset <= it.ofs;
		loc_length <= it.len;
		prefix <= it.oct;
		first_slot <= it.first;
		last_slot <= it.last;
		query_ip <= it.addr;
		do @(posedge clk); while (in_stall);
		case (it.md)
			MODE_WR_RANGE: begin
				if (it.slot < RANGE_DEPTH) begin
					rng_start[it.slot] = it.st;
					rng_end[it.slot] = it.en;
					rng_ofs[it.slot] = it.ofs;
					rng_len[it.slot] = it.len;
					rng_loaded[it.slot] = 1'b1;
				end
			end
			MODE_WR_PREFIX: begin
				oct_first[it.oct] = it.first;
				oct_last[it.oct] = it.last;
				oct_valid[it.oct] = 1'b1;
			end
			MODE_QUERY: begin
				lookup_expect.insert(lookup_expect.size(),
					typed ? want : predict_lookup(it.addr));
			end
			default: begin
			end
		endcase
		if (it.md != MODE_UNUSED)
			items_taken++;
		@(negedge clk);
	endtask

	// A lookup must never reach a range slot that was never loaded, so every such
	// slot on its search path is loaded first. Loading changes the path, hence the loop.
	task automatic issue_query(logic [ADDR_W-1:0] addr);
		bit clean;
		int unsigned gap_slot;
		logic [ADDR_W-1:0] st;
		clean = 1'b0;
		while (!clean) begin
			void'(predict_lookup(addr));
			clean = 1'b1;
			foreach (probe_path[i]) begin
				if (clean && !rng_loaded[SLOT_W'(probe_path[i])]) begin
					gap_slot = probe_path[i];
					clean = 1'b0;
				end
			end
			if (!clean) begin
				st = ($urandom_range(9) < 7) ? {addr[31:24], 24'($urandom)} : $urandom;
				send_item(range_item(SLOT_W'(gap_slot), st,
					st + $urandom_range(0, 32'h0003_FFFF),
					OFS_W'($urandom), LEN_W'($urandom)), 1'b0, '0);
			end
		end
		send_item(query_item(addr), 1'b0, '0);
	endtask

	// Loads a sorted set of ranges inside one first octet, points the prefix slot at
	// them and looks up addresses around them.
	task automatic run_slice_scenario();
		int unsigned n;
		int unsigned base;
		int unsigned span;
		int unsigned k;
		int unsigned pick;
		int unsigned i;
		logic [OCT_W-1:0] oct;
		logic [ADDR_W-1:0] st;
		logic [ADDR_W-1:0] en;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] lo_addr[$];
		logic [ADDR_W-1:0] hi_addr[$];
		oct = OCT_W'($urandom);
		n = ($urandom_range(9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 48);
		base = $urandom_range(0, RANGE_DEPTH - n);
		span = (1 << 24) / n;
		for (i = 0; i < n; i++) begin
			st = {oct, 24'h0} + i * span + $urandom_range(0, span / 4);
			en = st + $urandom_range(0, span / 2);
			if (i == n - 1 && $urandom_range(3) == 0)
				en = {oct, 24'hFF_FFFF};
			lo_addr.insert(lo_addr.size(), st);
			hi_addr.insert(hi_addr.size(), en);
			send_item(range_item(SLOT_W'(base + i), st, en, OFS_W'($urandom),
				LEN_W'($urandom)), 1'b0, '0);
		end
		// Now and then the slice bounds arrive swapped.
		if ($urandom_range(9) == 0)
			send_item(prefix_item(oct, SLOT_W'(base + n - 1), SLOT_W'(base)), 1'b0, '0);
		else
			send_item(prefix_item(oct, SLOT_W'(base), SLOT_W'(base + n - 1)), 1'b0, '0);
		k = $urandom_range(2, 8);
		repeat (k) begin
			pick = $urandom_range(0, n - 1);
			case ($urandom_range(9))
				0, 1, 2, 3: addr = lo_addr[pick] + $urandom_range(0, hi_addr[pick] - lo_addr[pick]);
				4: addr = lo_addr[pick];
				5: addr = hi_addr[pick];
				6: addr = hi_addr[pick] + 1;
				7, 8: addr = {oct, 24'($urandom)};
				default: addr = $urandom;
			endcase
			issue_query(addr);
		end
	endtask

	task automatic run_noise_item();
		item_t it;
		it = noise_item();
		case ($urandom_range(5))
			0: begin
				it.md = MODE_UNUSED;
				send_item(it, 1'b0, '0);
			end
			1: begin
				it.md = MODE_WR_RANGE;
				send_item(it, 1'b0, '0);
			end
			2: begin
				// Arbitrary slice bounds, up to the whole table, then a lookup in it.
				it.md = MODE_WR_PREFIX;
				send_item(it, 1'b0, '0);
				issue_query({it.oct, 24'($urandom)});
			end
			default: issue_query($urandom);
		endcase
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			fail_count++;
		end
	endtask

	// Every result taken is matched against the oldest lookup still waiting.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (lookup_expect.size() == 0) begin
				$error("result item with no lookup waiting");
				fail_count++;
			end else begin
				oldest_lookup = lookup_expect.pop_front();
				check_field("hit", 32'(oldest_lookup.hit), 32'(hit));
				check_field("found_index", 32'(oldest_lookup.idx), 32'(found_index));
				check_field("found_start", oldest_lookup.st, found_start);
				check_field("found_end", oldest_lookup.en, found_end);
				check_field("found_offset", 32'(oldest_lookup.ofs), 32'(found_offset));
				check_field("found_length", 32'(oldest_lookup.len), 32'(found_length));
			end
		end
	end

	initial begin
		int unsigned rand_base;
		int unsigned phase;
		item_t dropped;

		dropped = '1;
		dropped.md = MODE_UNUSED;

		// Lookups before any prefix is loaded must all report a missing prefix.
		add_row('{query_item(32'h0A00_0001), 1'b1, NO_PREFIX});
		add_row('{query_item(32'hFFFF_FFFF), 1'b1, NO_PREFIX});
		add_row('{query_item(32'h0000_0000), 1'b1, NO_PREFIX});
		// The two end slots of the table, each a single-entry slice.
		add_row('{range_item(16'h0000, 32'h0000_0000, 32'h00FF_FFFF, 24'hFF_FFFF,
			8'hFF), 1'b0, '0});
		add_row('{range_item(16'hFFFF, 32'hFF00_0000, 32'hFFFF_FFFF, 24'h00_0000,
			8'h00), 1'b0, '0});
		add_row('{prefix_item(8'h00, 16'h0000, 16'h0000), 1'b0, '0});
		add_row('{prefix_item(8'hFF, 16'hFFFF, 16'hFFFF), 1'b0, '0});
		add_row('{query_item(32'h0000_0000), 1'b1,
			lookup_t'{1'b1, 16'h0000, 32'h0000_0000, 32'h00FF_FFFF, 24'hFF_FFFF, 8'hFF}});
		add_row('{query_item(32'h00FF_FFFF), 1'b1,
			lookup_t'{1'b1, 16'h0000, 32'h0000_0000, 32'h00FF_FFFF, 24'hFF_FFFF, 8'hFF}});
		add_row('{query_item(32'hFFFF_FFFF), 1'b1,
			lookup_t'{1'b1, 16'hFFFF, 32'hFF00_0000, 32'hFFFF_FFFF, 24'h00_0000, 8'h00}});
		add_row('{query_item(32'hFF00_0000), 1'b1,
			lookup_t'{1'b1, 16'hFFFF, 32'hFF00_0000, 32'hFFFF_FFFF, 24'h00_0000, 8'h00}});
		// A three-slot slice with gaps between its ranges.
		add_row('{range_item(16'd1, 32'h0A00_0000, 32'h0A00_00FF, 24'h12_3456,
			8'h01), 1'b0, '0});
		add_row('{range_item(16'd2, 32'h0A00_0200, 32'h0A00_02FF, 24'hAB_CDEF,
			8'h80), 1'b0, '0});
		add_row('{range_item(16'd3, 32'h0A00_1000, 32'h0A00_FFFF, 24'h00_0001,
			8'h7F), 1'b0, '0});
		add_row('{prefix_item(8'h0A, 16'd1, 16'd3), 1'b0, '0});
		add_row('{query_item(32'h0A00_0010), 1'b0, '0});
		add_row('{query_item(32'h0A00_0150), 1'b0, '0});
		add_row('{query_item(32'h0A00_0200), 1'b0, '0});
		add_row('{query_item(32'h0A00_02FF), 1'b0, '0});
		// Past every end in the slice, so slot 0 is checked.
		add_row('{query_item(32'h0AFF_FFFF), 1'b0, '0});
		// Reversed slice bounds: no search, slot 0 is checked.
		add_row('{prefix_item(8'h0B, 16'd5, 16'd2), 1'b0, '0});
		add_row('{query_item(32'h0B12_3456), 1'b0, '0});
		add_row('{dropped, 1'b0, '0});
		add_row('{query_item(32'h7F00_0000), 1'b1, NO_PREFIX});
		// A slice over the whole table, for the longest search.
		add_row('{prefix_item(8'h0C, 16'h0000, 16'hFFFF), 1'b0, '0});
		add_row('{query_item(32'h0C80_0000), 1'b0, '0});

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[r]) begin
			if (dir_rows[r].it.md == MODE_QUERY && !dir_rows[r].typed)
				issue_query(dir_rows[r].it.addr);
			else
				send_item(dir_rows[r].it, dir_rows[r].typed, dir_rows[r].want);
		end

		// Random part in three idling phases: sender light, then receiver light, then none.
		rand_base = items_taken;
		while (items_taken - rand_base < RANDOM_ITEMS) begin
			phase = (items_taken - rand_base) * 3 / RANDOM_ITEMS;
			case (phase)
				0: begin
					send_gap_pct = 23;
					recv_stall_pct = 45;
				end
				1: begin
					send_gap_pct = 45;
					recv_stall_pct = 23;
				end
				default: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			if ($urandom_range(9) < 7)
				run_slice_scenario();
			else
				run_noise_item();
		end
		in_valid <= 1'b0;

		while (lookup_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && lookup_expect.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
